/* hw/rtl/iba_pkg.sv */
package iba_pkg;

    // default sizing
    localparam int NUM_BLOCKS_DEF  = 16;
    localparam int FILE_SLOTS_DEF  = 16;
    localparam int BLOCK_BYTES_DEF = 64;

    // fixed widths of the request and result fields
    localparam int SIZE_W     = 11;
    localparam int PORT_SLOT_W = 4;
    localparam int PORT_BLK_W  = 4;

    typedef logic [1:0] status_t;

    localparam status_t STAT_OK     = 2'd0;
    localparam status_t STAT_NOMEM  = 2'd1;
    localparam status_t STAT_FULL   = 2'd2;
    localparam status_t STAT_ABSENT = 2'd3;

    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_DEL_CNT,
        S_DEL_RD,
        S_DEL_FREE
    } iba_state_t;

    // write enables from the engine to the table memories
    typedef struct packed {
        logic cnt_we;
        logic list_we;
    } iba_mem_ctl_t;

endpackage

/* hw/rtl/iba_store.sv */
module iba_store #(
    parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF,
    parameter int FILE_SLOTS = iba_pkg::FILE_SLOTS_DEF,
    localparam int BLK_W  = $clog2(NUM_BLOCKS),
    localparam int SLOT_W = $clog2(FILE_SLOTS),
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1)
) (
    input  logic                 clk,
    input  iba_pkg::iba_mem_ctl_t mem_ctl,
    input  logic [SLOT_W-1:0]    cnt_waddr,
    input  logic [CNT_W-1:0]     cnt_wdata,
    input  logic [SLOT_W-1:0]    cnt_raddr,
    output logic [CNT_W-1:0]     cnt_rdata,
    input  logic [SLOT_W-1:0]    list_slot,
    input  logic [BLK_W-1:0]     list_idx,
    input  logic [BLK_W-1:0]     list_wdata,
    output logic [BLK_W-1:0]     list_rdata
);
    import iba_pkg::*;

    logic [CNT_W-1:0] cnt_mem [FILE_SLOTS];
    logic [BLK_W-1:0] list_mem [FILE_SLOTS][NUM_BLOCKS];
    logic [CNT_W-1:0] cnt_rdata_reg;
    logic [BLK_W-1:0] list_rdata_reg;

    // per-slot block count, registered read
    always_ff @(posedge clk)
    begin
        if (mem_ctl.cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    // per-slot block list, registered read
    always_ff @(posedge clk)
    begin
        if (mem_ctl.list_we)
        begin
            list_mem[list_slot][list_idx] <= list_wdata;
        end
        list_rdata_reg <= list_mem[list_slot][list_idx];
    end

    assign cnt_rdata  = cnt_rdata_reg;
    assign list_rdata = list_rdata_reg;

endmodule

/* hw/rtl/iba_engine.sv */
module iba_engine #(
    parameter int NUM_BLOCKS  = iba_pkg::NUM_BLOCKS_DEF,
    parameter int FILE_SLOTS  = iba_pkg::FILE_SLOTS_DEF,
    parameter int BLOCK_BYTES = iba_pkg::BLOCK_BYTES_DEF,
    localparam int BLK_W  = $clog2(NUM_BLOCKS),
    localparam int SLOT_W = $clog2(FILE_SLOTS),
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          action,
    input  logic [iba_pkg::SIZE_W-1:0]    byte_size,
    input  logic [iba_pkg::PORT_SLOT_W-1:0] file_slot,
    output logic                          busy,
    output logic                          strobe,
    output iba_pkg::status_t              status,
    output logic [iba_pkg::PORT_SLOT_W-1:0] slot_out,
    output logic [iba_pkg::PORT_BLK_W-1:0]  block_index,
    output logic                          last,
    output iba_pkg::iba_mem_ctl_t         mem_ctl,
    output logic [SLOT_W-1:0]             cnt_waddr,
    output logic [CNT_W-1:0]              cnt_wdata,
    output logic [SLOT_W-1:0]             cnt_raddr,
    input  logic [CNT_W-1:0]              cnt_rdata,
    output logic [SLOT_W-1:0]             list_slot,
    output logic [BLK_W-1:0]              list_idx,
    output logic [BLK_W-1:0]              list_wdata,
    input  logic [BLK_W-1:0]              list_rdata
);
    import iba_pkg::*;

    iba_state_t state_reg, state_next;

    logic [NUM_BLOCKS-1:0] used_map_reg, used_map_next;
    logic [CNT_W-1:0]      free_blocks_reg, free_blocks_next;
    logic [FILE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  strobe_reg, strobe_next;
    status_t               status_reg, status_next;
    logic [PORT_SLOT_W-1:0] slot_out_reg, slot_out_next;
    logic [PORT_BLK_W-1:0]  block_index_reg, block_index_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic [SIZE_W-1:0]     size_eff;
    logic                  nomem;
    logic [BLK_W-1:0]      free_blk;
    logic [SLOT_W-1:0]     free_slot;
    logic                  any_slot;
    logic                  slot_in_range;
    logic [SLOT_W-1:0]     slot_in_idx;
    logic                  absent;
    logic                  alloc_last;
    logic [CNT_W-1:0]      idx_inc;
    logic                  del_last;

    // request decode
    assign accept        = start && (state_reg == S_IDLE);
    assign busy          = (state_reg != S_IDLE);
    assign size_eff      = (byte_size == '0) ? SIZE_W'(1) : byte_size;
    assign nomem         = 32'(size_eff) > (32'(free_blocks_reg) * BLOCK_BYTES);
    assign any_slot      = !(&slot_valid_reg);
    assign slot_in_range = 32'(file_slot) < FILE_SLOTS;
    assign slot_in_idx   = SLOT_W'(file_slot);
    assign absent        = !slot_in_range || !slot_valid_reg[slot_in_idx];
    assign alloc_last    = 32'(rem_reg) <= BLOCK_BYTES;
    assign idx_inc       = idx_reg + CNT_W'(1);
    assign del_last      = (idx_inc == cnt_reg);

    // lowest free block
    always_comb
    begin
        free_blk = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--)
        begin
            if (!used_map_reg[i])
            begin
                free_blk = BLK_W'(i);
            end
        end
    end

    // lowest empty slot
    always_comb
    begin
        free_slot = '0;
        for (int i = FILE_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_CREATE)
                    begin
                        if (!nomem && any_slot)
                        begin
                            state_next = S_ALLOC;
                        end
                    end
                    else if (!absent)
                    begin
                        state_next = S_DEL_CNT;
                    end
                end
            end
            S_ALLOC:
            begin
                if (alloc_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DEL_CNT:
            begin
                state_next = S_DEL_RD;
            end
            S_DEL_RD:
            begin
                state_next = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                state_next = del_last ? S_IDLE : S_DEL_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // map updates, memory accesses and results
    always_comb
    begin
        used_map_next    = used_map_reg;
        free_blocks_next = free_blocks_reg;
        slot_valid_next  = slot_valid_reg;
        slot_next        = slot_reg;
        rem_next         = rem_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        strobe_next      = 1'b0;
        status_next      = status_reg;
        slot_out_next    = slot_out_reg;
        block_index_next = block_index_reg;
        last_next        = last_reg;
        mem_ctl          = '0;
        cnt_wdata        = idx_inc;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_CREATE)
                    begin
                        if (nomem)
                        begin
                            strobe_next      = 1'b1;
                            status_next      = STAT_NOMEM;
                            slot_out_next    = '0;
                            block_index_next = '0;
                            last_next        = 1'b1;
                        end
                        else if (!any_slot)
                        begin
                            strobe_next      = 1'b1;
                            status_next      = STAT_FULL;
                            slot_out_next    = '0;
                            block_index_next = '0;
                            last_next        = 1'b1;
                        end
                        else
                        begin
                            slot_next = free_slot;
                            rem_next  = size_eff;
                            idx_next  = '0;
                        end
                    end
                    else if (absent)
                    begin
                        strobe_next      = 1'b1;
                        status_next      = STAT_ABSENT;
                        slot_out_next    = file_slot;
                        block_index_next = '0;
                        last_next        = 1'b1;
                    end
                    else
                    begin
                        slot_next = slot_in_idx;
                    end
                end
            end
            S_ALLOC:
            begin
                // claim one block and log it in the slot's list
                used_map_next[free_blk] = 1'b1;
                free_blocks_next        = free_blocks_reg - CNT_W'(1);
                mem_ctl.list_we         = 1'b1;
                strobe_next             = 1'b1;
                status_next             = STAT_OK;
                slot_out_next           = PORT_SLOT_W'(slot_reg);
                block_index_next        = PORT_BLK_W'(free_blk);
                last_next               = alloc_last;
                if (alloc_last)
                begin
                    mem_ctl.cnt_we            = 1'b1;
                    slot_valid_next[slot_reg] = 1'b1;
                end
                else
                begin
                    idx_next = idx_inc;
                    rem_next = rem_reg - SIZE_W'(BLOCK_BYTES);
                end
            end
            S_DEL_CNT:
            begin
                cnt_next = cnt_rdata;
                idx_next = '0;
            end
            S_DEL_RD:
            begin
                // list read in flight
            end
            S_DEL_FREE:
            begin
                used_map_next[list_rdata] = 1'b0;
                free_blocks_next          = free_blocks_reg + CNT_W'(1);
                if (del_last)
                begin
                    slot_valid_next[slot_reg] = 1'b0;
                    strobe_next               = 1'b1;
                    status_next               = STAT_OK;
                    slot_out_next             = PORT_SLOT_W'(slot_reg);
                    block_index_next          = '0;
                    last_next                 = 1'b1;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    // memory addressing
    assign cnt_waddr  = slot_reg;
    assign cnt_raddr  = slot_in_idx;
    assign list_slot  = slot_reg;
    assign list_idx   = idx_reg[BLK_W-1:0];
    assign list_wdata = free_blk;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_map_reg    <= '0;
            free_blocks_reg <= CNT_W'(NUM_BLOCKS);
            slot_valid_reg  <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_map_reg    <= used_map_next;
            free_blocks_reg <= free_blocks_next;
            slot_valid_reg  <= slot_valid_next;
            strobe_reg      <= strobe_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        rem_reg         <= rem_next;
        idx_reg         <= idx_next;
        cnt_reg         <= cnt_next;
        status_reg      <= status_next;
        slot_out_reg    <= slot_out_next;
        block_index_reg <= block_index_next;
        last_reg        <= last_next;
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign block_index = block_index_reg;
    assign last        = last_reg;

endmodule

/* hw/rtl/indexed_block_allocator_top.sv */
// channel   signals                                   direction  handshake
// request   action, byte_size, file_slot              in         start high, busy low
// result    status, slot_out, block_index, last       out        strobe, one cycle
//
// a create is checked first, then claims its blocks one by one, giving one
// result per cycle back to back; errors answer in the cycle after the request.
// a delete does one count memory read, then one list memory read and one map
// update per block held by the slot. reset clears the block map and slot table
// and sets the free count to NUM_BLOCKS at once; no clearing pass.
// results cannot be held off; busy falls as the final result of a request shows.
module indexed_block_allocator_top #(
    parameter int NUM_BLOCKS  = iba_pkg::NUM_BLOCKS_DEF,
    parameter int FILE_SLOTS  = iba_pkg::FILE_SLOTS_DEF,
    parameter int BLOCK_BYTES = iba_pkg::BLOCK_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [iba_pkg::SIZE_W-1:0]      byte_size,
    input  logic [iba_pkg::PORT_SLOT_W-1:0] file_slot,
    output logic                            strobe,
    output iba_pkg::status_t                status,
    output logic [iba_pkg::PORT_SLOT_W-1:0] slot_out,
    output logic [iba_pkg::PORT_BLK_W-1:0]  block_index,
    output logic                            last
);
    import iba_pkg::*;

    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int SLOT_W = $clog2(FILE_SLOTS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

    iba_mem_ctl_t       mem_ctl;
    logic [SLOT_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [SLOT_W-1:0]  cnt_raddr;
    logic [CNT_W-1:0]   cnt_rdata;
    logic [SLOT_W-1:0]  list_slot;
    logic [BLK_W-1:0]   list_idx;
    logic [BLK_W-1:0]   list_wdata;
    logic [BLK_W-1:0]   list_rdata;

    // allocation control and maps
    iba_engine #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .FILE_SLOTS  (FILE_SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .byte_size   (byte_size),
        .file_slot   (file_slot),
        .busy        (busy),
        .strobe      (strobe),
        .status      (status),
        .slot_out    (slot_out),
        .block_index (block_index),
        .last        (last),
        .mem_ctl     (mem_ctl),
        .cnt_waddr   (cnt_waddr),
        .cnt_wdata   (cnt_wdata),
        .cnt_raddr   (cnt_raddr),
        .cnt_rdata   (cnt_rdata),
        .list_slot   (list_slot),
        .list_idx    (list_idx),
        .list_wdata  (list_wdata),
        .list_rdata  (list_rdata)
    );

    // file table memories
    iba_store #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .FILE_SLOTS (FILE_SLOTS)
    ) u_store (
        .clk        (clk),
        .mem_ctl    (mem_ctl),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .cnt_raddr  (cnt_raddr),
        .cnt_rdata  (cnt_rdata),
        .list_slot  (list_slot),
        .list_idx   (list_idx),
        .list_wdata (list_wdata),
        .list_rdata (list_rdata)
    );

    // the final result of a request frees the request port
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("busy still high with final result");

    // block results of one create come on consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a create result run");

    // error results are single and carry no block
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != STAT_OK) |-> last && (block_index == '0))
        else $error("malformed error result");

    // work only starts from a request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

endmodule
